FILE: src/mbx_pkg.sv
package mbx_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int MSG_BYTES    = 64;
  localparam int READ_CAP_MAX = 64;

  localparam int LEN_W   = 7;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int OFF_W   = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int ADDR_W  = 1 + PTR_W + OFF_W;
  localparam int LADDR_W = 1 + PTR_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BLOCK   = 2'd2,
    ST_CLOSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_ADDR,
    S_DATA
  } seq_state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             side;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [LEN_W-1:0] read_capacity;
  } in_beat_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] length;
    logic [7:0]       out_byte;
    logic             last;
  } res_t;

  typedef struct packed {
    logic               byte_we;
    logic [ADDR_W-1:0]  byte_waddr;
    logic [7:0]         byte_wdata;
    logic               byte_re;
    logic [ADDR_W-1:0]  byte_raddr;
    logic               len_we;
    logic [LADDR_W-1:0] len_waddr;
    logic [LEN_W-1:0]   len_wdata;
    logic               len_re;
    logic [LADDR_W-1:0] len_raddr;
  } store_req_t;

  typedef struct packed {
    logic [7:0]       byte_rdata;
    logic [LEN_W-1:0] len_rdata;
  } store_rsp_t;

endpackage

FILE: src/mbx_if.sv
interface mbx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       side;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [6:0] read_capacity;

  modport source (output valid, op, side, data_byte, last_byte, read_capacity,
                  input ready);
  modport sink (input valid, op, side, data_byte, last_byte, read_capacity,
                output ready);
endinterface

interface mbx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] length;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, status, length, out_byte, last, input ready);
  modport sink (input valid, status, length, out_byte, last, output ready);
endinterface

FILE: src/mbx_store.sv
module mbx_store (
  input  logic                clk,
  input  mbx_pkg::store_req_t req,
  output mbx_pkg::store_rsp_t rsp
);
  import mbx_pkg::*;

  // byte store: {ring, slot, offset}, length store: {ring, slot}
  logic [7:0]       byte_mem [2**ADDR_W];
  logic [LEN_W-1:0] len_mem  [2**LADDR_W];

  always_ff @(posedge clk) begin
    if (req.byte_we) begin
      byte_mem[req.byte_waddr] <= req.byte_wdata;
    end
    if (req.byte_re) begin
      rsp.byte_rdata <= byte_mem[req.byte_raddr];
    end
    if (req.len_we) begin
      len_mem[req.len_waddr] <= req.len_wdata;
    end
    if (req.len_re) begin
      rsp.len_rdata <= len_mem[req.len_raddr];
    end
  end

endmodule

FILE: src/mbx_ctrl.sv
module mbx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbx_pkg::in_beat_t   beat,
  input  logic                slot_free,
  output logic                res_load,
  output mbx_pkg::res_t       res,
  output mbx_pkg::store_req_t sreq,
  input  mbx_pkg::store_rsp_t srsp
);
  import mbx_pkg::*;

  seq_state_t       state, state_next;
  logic [PTR_W-1:0] head [2], head_next [2];
  logic [PTR_W-1:0] tail [2], tail_next [2];
  logic [CNT_W-1:0] fill [2], fill_next [2];
  logic             open [2], open_next [2];
  logic [LEN_W-1:0] asm_len [2], asm_len_next [2];
  status_t          drop [2], drop_next [2];

  logic             rd_side, rd_side_next;
  logic [PTR_W-1:0] rd_slot, rd_slot_next;
  logic [LEN_W-1:0] rd_cap, rd_cap_next;
  logic [LEN_W-1:0] rd_len, rd_len_next;
  logic [LEN_W-1:0] rd_idx, rd_idx_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      for (int i = 0; i < 2; i++) begin
        head[i]    <= '0;
        tail[i]    <= '0;
        fill[i]    <= '0;
        open[i]    <= 1'b1;
        asm_len[i] <= '0;
        drop[i]    <= ST_OK;
      end
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      fill    <= fill_next;
      open    <= open_next;
      asm_len <= asm_len_next;
      drop    <= drop_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_side <= rd_side_next;
    rd_slot <= rd_slot_next;
    rd_cap  <= rd_cap_next;
    rd_len  <= rd_len_next;
    rd_idx  <= rd_idx_next;
  end

  always_comb begin
    logic             s;
    logic             p;
    logic             peer_full;
    status_t          dc;
    logic [LEN_W-1:0] al;
    logic [LEN_W-1:0] mlen;

    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    fill_next    = fill;
    open_next    = open;
    asm_len_next = asm_len;
    drop_next    = drop;
    rd_side_next = rd_side;
    rd_slot_next = rd_slot;
    rd_cap_next  = rd_cap;
    rd_len_next  = rd_len;
    rd_idx_next  = rd_idx;
    in_ready     = 1'b0;
    res_load     = 1'b0;
    res          = '0;
    sreq         = '0;

    s         = beat.side;
    p         = ~beat.side;
    peer_full = (fill[p] == CNT_W'(QUEUE_DEPTH));
    dc        = drop[s];
    al        = asm_len[s];
    mlen      = (srsp.len_rdata > LEN_W'(MSG_BYTES)) ? LEN_W'(MSG_BYTES) : srsp.len_rdata;

    unique case (state)
      S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          unique case (beat.op)
            OP_WRITE: begin
              // first byte checks the peer, an overlong byte starts a drop
              if (dc == ST_OK && al == '0) begin
                if (!open[p]) begin
                  dc = ST_CLOSED;
                end else if (peer_full) begin
                  dc = ST_BLOCK;
                end
              end
              if (dc == ST_OK && al >= LEN_W'(MSG_BYTES)) begin
                dc = ST_INVALID;
                al = '0;
              end
              res_load = 1'b1;
              res.last = 1'b1;
              if (dc != ST_OK) begin
                res.status      = dc;
                drop_next[s]    = beat.last_byte ? ST_OK : dc;
                asm_len_next[s] = al;
              end else begin
                sreq.byte_we    = 1'b1;
                sreq.byte_waddr = {p, tail[p], al[OFF_W-1:0]};
                sreq.byte_wdata = beat.data_byte;
                al              = al + 1'b1;
                res.status      = ST_OK;
                res.length      = al;
                if (!beat.last_byte) begin
                  asm_len_next[s] = al;
                end else begin
                  asm_len_next[s] = '0;
                  if (!open[p] || peer_full) begin
                    res.status = open[p] ? ST_BLOCK : ST_CLOSED;
                    res.length = '0;
                  end else begin
                    sreq.len_we    = 1'b1;
                    sreq.len_waddr = {p, tail[p]};
                    sreq.len_wdata = al;
                    tail_next[p]   = ptr_inc(tail[p]);
                    fill_next[p]   = fill[p] + 1'b1;
                  end
                end
              end
            end
            OP_READ: begin
              if (fill[s] == '0) begin
                res_load   = 1'b1;
                res.status = ST_BLOCK;
                res.last   = 1'b1;
              end else begin
                sreq.len_re    = 1'b1;
                sreq.len_raddr = {s, head[s]};
                rd_side_next   = s;
                rd_slot_next   = head[s];
                rd_cap_next    = (beat.read_capacity > LEN_W'(READ_CAP_MAX)) ?
                                 LEN_W'(READ_CAP_MAX) : beat.read_capacity;
                state_next     = S_LEN;
              end
            end
            OP_CLOSE: begin
              open_next[s]    = 1'b0;
              asm_len_next[s] = '0;
              drop_next[s]    = ST_OK;
              if (!open[p]) begin
                for (int i = 0; i < 2; i++) begin
                  head_next[i] = '0;
                  tail_next[i] = '0;
                  fill_next[i] = '0;
                end
              end
              res_load   = 1'b1;
              res.status = ST_OK;
              res.last   = 1'b1;
            end
            default: begin
              res_load   = 1'b1;
              res.status = ST_INVALID;
              res.last   = 1'b1;
            end
          endcase
        end
      end
      S_LEN: begin
        if (slot_free) begin
          if (rd_cap < mlen) begin
            // too small: report and leave the message queued
            res_load   = 1'b1;
            res.status = ST_INVALID;
            res.length = mlen;
            res.last   = 1'b1;
            state_next = S_IDLE;
          end else begin
            head_next[rd_side] = ptr_inc(head[rd_side]);
            fill_next[rd_side] = fill[rd_side] - 1'b1;
            if (mlen == '0) begin
              res_load   = 1'b1;
              res.status = ST_OK;
              res.last   = 1'b1;
              state_next = S_IDLE;
            end else begin
              rd_len_next = mlen;
              rd_idx_next = '0;
              state_next  = S_ADDR;
            end
          end
        end
      end
      S_ADDR: begin
        sreq.byte_re    = 1'b1;
        sreq.byte_raddr = {rd_side, rd_slot, rd_idx[OFF_W-1:0]};
        state_next      = S_DATA;
      end
      S_DATA: begin
        if (slot_free) begin
          res_load     = 1'b1;
          res.status   = ST_OK;
          res.length   = rd_len;
          res.out_byte = srsp.byte_rdata;
          res.last     = (rd_idx + 1'b1 == rd_len);
          rd_idx_next  = rd_idx + 1'b1;
          state_next   = res.last ? S_IDLE : S_ADDR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/dual_mailbox_message_fifo_top.sv
// channel  dir  payload                                            handshake
// req      in   op, side, data_byte, last_byte, read_capacity      valid/ready
// rsp      out  status, length, out_byte, last                     valid/ready
//
// a write byte, close, bad op or read of an empty ring is handled from idle and
// yields one beat
// a read first fetches the queued length, then reads each message byte in turn
// (registered byte-store read, then the output register)
// req.ready is low while a read runs and while the output register is full and not being taken
// rsp stalls hold the output register and pause the read sequencer
// synchronous reset: both sides open, all rings empty; stores need no clearing
module dual_mailbox_message_fifo_top (
  input logic       clk,
  input logic       rst,
  mbx_in_if.sink    req,
  mbx_out_if.source rsp
);
  import mbx_pkg::*;

  in_beat_t   beat;
  res_t       res;
  res_t       res_q;
  logic       res_load;
  logic       ready;
  logic       out_valid;
  logic       slot_free;
  store_req_t sreq;
  store_rsp_t srsp;

  // collect the request payload into one beat
  assign beat.op            = req.op;
  assign beat.side          = req.side;
  assign beat.data_byte     = req.data_byte;
  assign beat.last_byte     = req.last_byte;
  assign beat.read_capacity = req.read_capacity;

  assign req.ready = ready;

  // output register frees when empty or being taken this cycle
  assign slot_free = !out_valid || rsp.ready;

  mbx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (ready),
    .beat      (beat),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res),
    .sreq      (sreq),
    .srsp      (srsp)
  );

  mbx_store u_store (
    .clk (clk),
    .req (sreq),
    .rsp (srsp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = res_q.status;
  assign rsp.length   = res_q.length;
  assign rsp.out_byte = res_q.out_byte;
  assign rsp.last     = res_q.last;

endmodule

FILE: tb/sv/dual_mailbox_message_fifo_top_test.sv
`timescale 1ns / 100ps

module dual_mailbox_message_fifo_top_test;
  import mbx_pkg::*;

  // op code the block must reject with invalid argument
  localparam logic [1:0] OP_BAD = 2'd3;
  // slowest legal run: a few hundred items, each read up to 64 beats plus
  // receiver stalls, with wide margin on top
  localparam int CYCLE_LIMIT = 500000;

  // a stimulus table row; pinned rows carry a hand-typed single response
  typedef struct {
    in_beat_t beat;
    bit       pinned;
    res_t     res;
  } stim_row_t;

  logic clk;
  logic rst;

  mbx_in_if  req_if ();
  mbx_out_if rsp_if ();

  dual_mailbox_message_fifo_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // idle odds in percent for each side, and the receiver hold-off
  int send_idle_pct = 34;
  int recv_idle_pct = 73;
  int rsp_hold_left = 0;
  int err_count     = 0;
  int cycle_count   = 0;

  // response beats owed by the block, oldest first
  res_t rsp_beats_due[$];

  // mailbox state mirror: both rings, their lengths, pointers and the
  // per-writer assembly and drop state
  bit [7:0]       mb_bytes [2][QUEUE_DEPTH][MSG_BYTES];
  bit [LEN_W-1:0] mb_len   [2][QUEUE_DEPTH];
  int unsigned    mb_head  [2];
  int unsigned    mb_tail  [2];
  int unsigned    mb_fill  [2];
  int unsigned    mb_asm   [2];
  bit             mb_open  [2];
  status_t        mb_drop  [2];

  function automatic res_t mk_res(status_t st, int unsigned n, bit [7:0] d, bit l);
    res_t r;
    r.status   = st;
    r.length   = n[LEN_W-1:0];
    r.out_byte = d;
    r.last     = l;
    return r;
  endfunction

  function automatic in_beat_t mk_beat(logic [1:0] op, bit sd, bit [7:0] d, bit lb,
                                       bit [6:0] cap);
    in_beat_t b;
    b.op            = op;
    b.side          = sd;
    b.data_byte     = d;
    b.last_byte     = lb;
    b.read_capacity = cap;
    return b;
  endfunction

  function automatic stim_row_t row(logic [1:0] op, bit sd, bit [7:0] d, bit lb,
                                    bit [6:0] cap, bit pinned, status_t st,
                                    bit [6:0] n);
    stim_row_t r;
    r.beat   = mk_beat(op, sd, d, lb, cap);
    r.pinned = pinned;
    r.res    = mk_res(st, 32'(n), 8'h00, 1'b1);
    return r;
  endfunction

  // works out the response beats of one accepted request beat
  function automatic void mailbox_predict(in_beat_t b);
    int unsigned s, p, n, cap, slot, i;
    s = 32'(b.side);
    p = s ^ 1;
    case (b.op)
      OP_WRITE: begin
        // first byte: peer must be open and its ring not full
        if (mb_drop[s] == ST_OK && mb_asm[s] == 0) begin
          if (!mb_open[p])
            mb_drop[s] = ST_CLOSED;
          else if (mb_fill[p] >= QUEUE_DEPTH)
            mb_drop[s] = ST_BLOCK;
        end
        // overlong message
        if (mb_drop[s] == ST_OK && mb_asm[s] >= MSG_BYTES) begin
          mb_drop[s] = ST_INVALID;
          mb_asm[s]  = 0;
        end
        if (mb_drop[s] != ST_OK) begin
          rsp_beats_due.push_back(mk_res(mb_drop[s], 0, 8'h00, 1'b1));
          if (b.last_byte)
            mb_drop[s] = ST_OK;
        end else begin
          mb_bytes[p][mb_tail[p]][mb_asm[s]] = b.data_byte;
          mb_asm[s]++;
          n = mb_asm[s];
          if (!b.last_byte) begin
            rsp_beats_due.push_back(mk_res(ST_OK, n, 8'h00, 1'b1));
          end else begin
            mb_asm[s] = 0;
            // peer checked again at commit
            if (!mb_open[p] || mb_fill[p] >= QUEUE_DEPTH) begin
              rsp_beats_due.push_back(mk_res(mb_open[p] ? ST_BLOCK : ST_CLOSED, 0,
                                             8'h00, 1'b1));
            end else begin
              mb_len[p][mb_tail[p]] = n[LEN_W-1:0];
              mb_tail[p] = (mb_tail[p] + 1) % QUEUE_DEPTH;
              mb_fill[p]++;
              rsp_beats_due.push_back(mk_res(ST_OK, n, 8'h00, 1'b1));
            end
          end
        end
      end
      OP_READ: begin
        cap = (b.read_capacity > READ_CAP_MAX) ? READ_CAP_MAX : 32'(b.read_capacity);
        if (mb_fill[s] == 0) begin
          rsp_beats_due.push_back(mk_res(ST_BLOCK, 0, 8'h00, 1'b1));
        end else begin
          slot = mb_head[s];
          n    = 32'(mb_len[s][slot]);
          if (cap < n) begin
            // head message stays queued
            rsp_beats_due.push_back(mk_res(ST_INVALID, n, 8'h00, 1'b1));
          end else begin
            mb_head[s] = (slot + 1) % QUEUE_DEPTH;
            mb_fill[s]--;
            for (i = 0; i < n; i++)
              rsp_beats_due.push_back(mk_res(ST_OK, n, mb_bytes[s][slot][i], i + 1 == n));
          end
        end
      end
      OP_CLOSE: begin
        mb_open[s] = 1'b0;
        mb_asm[s]  = 0;
        mb_drop[s] = ST_OK;
        // both closed: rings emptied
        if (!mb_open[0] && !mb_open[1]) begin
          mb_head = '{0, 0};
          mb_tail = '{0, 0};
          mb_fill = '{0, 0};
        end
        rsp_beats_due.push_back(mk_res(ST_OK, 0, 8'h00, 1'b1));
      end
      default: rsp_beats_due.push_back(mk_res(ST_INVALID, 0, 8'h00, 1'b1));
    endcase
  endfunction

  function automatic void cmp_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endfunction

  // offers one request beat, with random idle cycles ahead of it, and
  // books its responses once the beat is taken
  task automatic send_beat(in_beat_t b, bit pinned, res_t pinned_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.op            <= b.op;
    req_if.side          <= b.side;
    req_if.data_byte     <= b.data_byte;
    req_if.last_byte     <= b.last_byte;
    req_if.read_capacity <= b.read_capacity;
    @(posedge clk);
    while (!req_if.ready)
      @(posedge clk);
    mailbox_predict(b);
    // a typed-in row replaces the single beat worked out above
    if (pinned) begin
      void'(rsp_beats_due.pop_back());
      rsp_beats_due.push_back(pinned_res);
    end
  endtask

  // side 0 writes la bytes and side 1 writes lb bytes, byte by byte in turn
  task automatic write_pair(int la, int lb);
    int i;
    for (i = 0; i < ((la > lb) ? la : lb); i++) begin
      if (i < la)
        send_beat(mk_beat(OP_WRITE, 1'b0, 8'($urandom_range(0, 255)), i == la - 1,
                          7'($urandom_range(0, 127))), 1'b0, '0);
      if (i < lb)
        send_beat(mk_beat(OP_WRITE, 1'b1, 8'($urandom_range(0, 255)), i == lb - 1,
                          7'($urandom_range(0, 127))), 1'b0, '0);
    end
  endtask

  task automatic read_msg(bit sd, bit [6:0] cap);
    send_beat(mk_beat(OP_READ, sd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      cap), 1'b0, '0);
  endtask

  task automatic close_side(bit sd);
    send_beat(mk_beat(OP_CLOSE, sd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      7'($urandom_range(0, 127))), 1'b1, mk_res(ST_OK, 0, 8'h00, 1'b1));
  endtask

  // mostly short messages, now and then up to the full size
  function automatic int msg_size();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 64);
  endfunction

  // random mix: single writers, interleaved writers, reads, bad ops
  task automatic random_traffic(int n_items);
    int done_items;
    int pick;
    int la;
    int lb;
    bit sd;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(0, 99);
      sd   = 1'($urandom_range(0, 1));
      if (pick < 45) begin
        la = msg_size();
        if (sd)
          write_pair(0, la);
        else
          write_pair(la, 0);
        done_items += la;
      end else if (pick < 60) begin
        la = msg_size();
        lb = msg_size();
        write_pair(la, lb);
        done_items += la + lb;
      end else if (pick < 95) begin
        // mostly enough room, sometimes any capacity at all
        read_msg(sd, 7'(($urandom_range(0, 99) < 60) ? $urandom_range(64, 127)
                                                     : $urandom_range(0, 127)));
        done_items++;
      end else begin
        send_beat(mk_beat(OP_BAD, sd, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 7'($urandom_range(0, 127))),
                  1'b0, '0);
      end
    end
  endtask

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("dual_mailbox_message_fifo_top_test: FAIL");
    $finish;
  end

  // response side: check each beat, then pick next cycle's ready
  initial begin
    res_t want;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_beats_due.size() == 0) begin
          err_count++;
          $display("%0t: response beat with none due: status %0d length %0d byte %0d last %0d",
                   $time, rsp_if.status, rsp_if.length, rsp_if.out_byte, rsp_if.last);
        end else begin
          want = rsp_beats_due.pop_front();
          cmp_field("status", 32'(want.status), 32'(rsp_if.status));
          cmp_field("length", 32'(want.length), 32'(rsp_if.length));
          cmp_field("out_byte", 32'(want.out_byte), 32'(rsp_if.out_byte));
          cmp_field("last", 32'(want.last), 32'(rsp_if.last));
        end
      end
      // long hold-off lets the block back up into its request side
      if (rsp_hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t dir_rows[$];

    req_if.valid         <= 1'b0;
    req_if.op            <= OP_WRITE;
    req_if.side          <= 1'b0;
    req_if.data_byte     <= 8'h00;
    req_if.last_byte     <= 1'b0;
    req_if.read_capacity <= 7'd0;
    rst                  <= 1'b1;

    // mirror starts as after reset: both sides open, rings empty
    foreach (mb_open[i]) begin
      mb_open[i] = 1'b1;
      mb_head[i] = 0;
      mb_tail[i] = 0;
      mb_fill[i] = 0;
      mb_asm[i]  = 0;
      mb_drop[i] = ST_OK;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows: op, side, byte, last, capacity, pinned, status, length
    // empty rings would block
    dir_rows.push_back(row(OP_READ,  1'b0, 8'h00, 1'b0, 7'd64,  1'b1, ST_BLOCK,   7'd0));
    dir_rows.push_back(row(OP_READ,  1'b1, 8'hFF, 1'b1, 7'd0,   1'b1, ST_BLOCK,   7'd0));
    // two-byte message from side 0 into ring 1, extreme bytes
    dir_rows.push_back(row(OP_WRITE, 1'b0, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,      7'd1));
    dir_rows.push_back(row(OP_WRITE, 1'b0, 8'hFF, 1'b1, 7'd127, 1'b1, ST_OK,      7'd2));
    // capacity too small leaves it queued, then a saturating capacity pops it
    dir_rows.push_back(row(OP_READ,  1'b1, 8'h00, 1'b0, 7'd1,   1'b1, ST_INVALID, 7'd2));
    dir_rows.push_back(row(OP_READ,  1'b1, 8'h00, 1'b0, 7'd127, 1'b0, ST_OK,      7'd0));
    dir_rows.push_back(row(OP_READ,  1'b1, 8'h00, 1'b0, 7'd64,  1'b1, ST_BLOCK,   7'd0));
    // one-byte message into ring 0, zero capacity, then exact fit
    dir_rows.push_back(row(OP_WRITE, 1'b1, 8'h80, 1'b1, 7'd0,   1'b1, ST_OK,      7'd1));
    dir_rows.push_back(row(OP_READ,  1'b0, 8'h00, 1'b0, 7'd0,   1'b1, ST_INVALID, 7'd1));
    dir_rows.push_back(row(OP_READ,  1'b0, 8'h00, 1'b0, 7'd1,   1'b0, ST_OK,      7'd0));
    // unknown op
    dir_rows.push_back(row(OP_BAD,   1'b0, 8'h55, 1'b1, 7'd127, 1'b1, ST_INVALID, 7'd0));
    // both sides assembling at once
    dir_rows.push_back(row(OP_WRITE, 1'b1, 8'h01, 1'b0, 7'd0,   1'b1, ST_OK,      7'd1));
    dir_rows.push_back(row(OP_WRITE, 1'b0, 8'h7F, 1'b0, 7'd0,   1'b1, ST_OK,      7'd1));
    dir_rows.push_back(row(OP_WRITE, 1'b1, 8'hFE, 1'b1, 7'd0,   1'b1, ST_OK,      7'd2));
    dir_rows.push_back(row(OP_WRITE, 1'b0, 8'h80, 1'b1, 7'd0,   1'b1, ST_OK,      7'd2));
    dir_rows.push_back(row(OP_READ,  1'b0, 8'hAA, 1'b1, 7'd2,   1'b0, ST_OK,      7'd0));
    dir_rows.push_back(row(OP_READ,  1'b1, 8'h55, 1'b0, 7'd65,  1'b0, ST_OK,      7'd0));
    dir_rows.push_back(row(OP_BAD,   1'b1, 8'hAA, 1'b0, 7'd0,   1'b1, ST_INVALID, 7'd0));

    foreach (dir_rows[k])
      send_beat(dir_rows[k].beat, dir_rows[k].pinned, dir_rows[k].res);

    // overlong message from side 1 is dropped, a short one from side 0 alongside
    write_pair(2, MSG_BYTES + 1);
    read_msg(1'b1, 7'd64);
    read_msg(1'b0, 7'd64);

    random_traffic(8);

    // roles swap: slow sender, busy receiver
    send_idle_pct = 73;
    recv_idle_pct = 34;

    // receiver holds off while side 0 overfills ring 1
    rsp_hold_left = 400;
    repeat (QUEUE_DEPTH + 1)
      write_pair(1, 0);
    repeat (QUEUE_DEPTH + 1)
      read_msg(1'b1, 7'd64);

    random_traffic(8);

    // no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(8);

    // peer closes while side 0 is mid-message: commit sees it closed
    repeat (3)
      send_beat(mk_beat(OP_WRITE, 1'b0, 8'($urandom_range(0, 255)), 1'b0, 7'd0), 1'b0, '0);
    close_side(1'b1);
    send_beat(mk_beat(OP_WRITE, 1'b0, 8'($urandom_range(0, 255)), 1'b1, 7'd0), 1'b0, '0);
    // closed side may still write to an open peer and read its own ring
    write_pair(0, 3);
    write_pair(2, 0);
    read_msg(1'b1, 7'd127);
    // a second close is harmless and abandons side 1's partial message
    send_beat(mk_beat(OP_WRITE, 1'b1, 8'($urandom_range(0, 255)), 1'b0, 7'd0), 1'b0, '0);
    send_beat(mk_beat(OP_WRITE, 1'b1, 8'($urandom_range(0, 255)), 1'b0, 7'd0), 1'b0, '0);
    close_side(1'b1);
    write_pair(0, 2);
    random_traffic(4);

    // both closed: rings emptied, everything blocks or drops from here on
    close_side(1'b0);
    close_side(1'b0);
    random_traffic(4);

    req_if.valid <= 1'b0;
    while (rsp_beats_due.size() != 0)
      @(posedge clk);
    // catch any stray beats
    repeat (40) @(posedge clk);

    if (err_count == 0)
      $display("dual_mailbox_message_fifo_top_test: PASS");
    else
      $display("dual_mailbox_message_fifo_top_test: FAIL");
    $finish;
  end

endmodule
